@@ rtl/ese_pkg.sv @@
// ----------------------------------------------------------------------------
// ese_pkg: shared types and constants of the exponential search engine
// Table geometry, field types, handshake payloads and the control and status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package ese_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int KEY_WIDTH   = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_COMPARE_SIGNED = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESENT_COUNT  = CSR_INDEX_W'(1);

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_SEARCH = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      IDX_ZERO,
      IDX_HI,
      IDX_MID
   } idx_sel_type;

   typedef struct packed {
      func_type    func;
      logic [9:0]  entry_index;
      logic [31:0] entry_value;
      logic [31:0] search_key;
      logic [10:0] probe_limit;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [9:0]  match_index;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_EXP_TEST,
      S_EXP_CMP,
      S_BIN_SETUP,
      S_BIN_TEST,
      S_BIN_CMP,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        exp_init;
      logic        exp_issue;
      logic        exp_advance;
      logic        bin_setup;
      logic        bin_issue;
      logic        bin_lo_up;
      logic        bin_hi_down;
      logic        res_set;
      status_type  res_status;
      idx_sel_type res_idx;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_write;
      logic limit_zero;
      logic absent0;
      logic exp_go;
      logic probe_zero;
      logic cmp_eq;
      logic cmp_lt;
      logic mid_present;
      logic range_ok;
      logic mid_zero;
   } stat_type;

endpackage

@@ rtl/exponential_search_engine.sv @@
// ----------------------------------------------------------------------------
// exponential_search_engine: sorted key table with exponential search
// Write items load keys, search items probe 0,1,2,4,... then binary-search
// the bracket; one result per item.
//
//   port group   direction  handshake            payload
//   req_         in         start & !busy        req_type
//   rsp_         out        rsp_valid (strobe)   rsp_type
//   csr_         in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A write item has its result set in S_START and strobed in S_RESP. A search
// checks the item, then probes entry 0, each doubling probe and each binary
// probe with one key memory read and then the compare on the registered read
// data; a test or a compare ends the doubling, the bracket is clamped, a
// range test or a compare ends the binary search, and the result is strobed.
// One item is in flight; busy stays high until the result strobe. Reset is
// synchronous; the key table is not cleared. The receiver cannot stall, so
// the strobe is the transfer.
// ----------------------------------------------------------------------------
module exponential_search_engine import ese_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]       csr_wdata
);

   cmd_type  cmd;
   stat_type stat;
   logic     start_accept;

   assign csr_ready = 1'b1;

   ese_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .stat         (stat),
      .busy         (busy),
      .start_accept (start_accept),
      .rsp_valid    (rsp_valid),
      .cmd          (cmd)
   );

   ese_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .start_accept (start_accept),
      .req_data     (req_data),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_data     (rsp_data)
   );

endmodule

@@ rtl/ese_dpath.sv @@
// ----------------------------------------------------------------------------
// ese_dpath: key table, search bounds and key comparator
// Holds the configuration registers, the key memory with registered read,
// the lo/hi/mid bounds and the result register; bounds and result follow the commands.
// ----------------------------------------------------------------------------
module ese_dpath import ese_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start_accept,
   input  req_type                req_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]       csr_wdata,
   input  cmd_type                cmd,
   output stat_type               stat,
   output rsp_type                rsp_data
);

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   logic [KEY_WIDTH-1:0] key_table [TABLE_DEPTH];

   logic                 signed_ff;
   logic [CNT_W-1:0]     count_ff;
   func_type             func_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [CNT_W-1:0]     limit_ff, limit_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     mid_ff;
   logic [KEY_WIDTH-1:0] rdata_ff;
   status_type           status_ff, status_in;
   logic [IDX_W-1:0]     index_ff, index_in;

   logic [CNT_W-1:0]     count_sat;
   logic [CNT_W-1:0]     hi_clamp;
   logic [CNT_W-1:0]     mid_calc;
   logic [IDX_W-1:0]     rd_addr;
   logic [KEY_WIDTH-1:0] cmp_a, cmp_b;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         signed_ff <= 1'b0;
         count_ff  <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_COMPARE_SIGNED) begin
            signed_ff <= csr_wdata[0];
         end else if (csr_index == CSR_PRESENT_COUNT) begin
            count_ff <= csr_wdata;
         end
      end
   end

   assign count_sat = (count_ff > DEPTH_C) ? DEPTH_C : count_ff;
   assign limit_in  = (req_data.probe_limit > DEPTH_C) ? DEPTH_C : req_data.probe_limit;

   // key memory: write on accepted write item, registered read
   always_ff @(posedge clock) begin
      if (start_accept && req_data.func == FUNC_WRITE &&
          {1'b0, req_data.entry_index} < DEPTH_C) begin
         key_table[req_data.entry_index] <= req_data.entry_value[KEY_WIDTH-1:0];
      end
      if (cmd.exp_issue || cmd.bin_issue) begin
         rdata_ff <= key_table[rd_addr];
      end
   end

   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_addr  = cmd.bin_issue ? mid_calc[IDX_W-1:0] : hi_ff[IDX_W-1:0];

   // clamp the bracket to the limit, then keep it at or above lo
   always_comb begin
      hi_clamp = (hi_ff >= limit_ff) ? (limit_ff - CNT_W'(1)) : hi_ff;
      if (hi_clamp < lo_ff) begin
         hi_clamp = lo_ff;
      end
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.exp_init) begin
         lo_in = '0;
         hi_in = '0;
      end else if (cmd.exp_advance) begin
         lo_in = (hi_ff == '0) ? '0 : hi_ff;
         hi_in = (hi_ff == '0) ? CNT_W'(1) : {hi_ff[CNT_W-2:0], 1'b0};
      end else if (cmd.bin_setup) begin
         hi_in = hi_clamp;
      end else if (cmd.bin_lo_up) begin
         lo_in = mid_ff + CNT_W'(1);
      end else if (cmd.bin_hi_down) begin
         hi_in = mid_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start_accept) begin
         func_ff  <= req_data.func;
         key_ff   <= req_data.search_key[KEY_WIDTH-1:0];
         limit_ff <= limit_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.bin_issue) begin
         mid_ff <= mid_calc;
      end
   end

   // two's complement order by flipping the sign bits in signed mode, else unsigned order
   assign cmp_a = rdata_ff ^ {signed_ff, {(KEY_WIDTH-1){1'b0}}};
   assign cmp_b = key_ff   ^ {signed_ff, {(KEY_WIDTH-1){1'b0}}};

   assign stat.is_write    = (func_ff == FUNC_WRITE);
   assign stat.limit_zero  = (limit_ff == '0);
   assign stat.absent0     = (count_sat == '0);
   assign stat.exp_go      = (hi_ff < limit_ff) && (hi_ff < count_sat);
   assign stat.probe_zero  = (hi_ff == '0);
   assign stat.cmp_eq      = (cmp_a == cmp_b);
   assign stat.cmp_lt      = (cmp_a < cmp_b);
   assign stat.mid_present = (mid_ff < count_sat);
   assign stat.range_ok    = (lo_ff <= hi_ff);
   assign stat.mid_zero    = (mid_ff == '0);

   // result register
   always_comb begin
      status_in = status_ff;
      index_in  = index_ff;
      if (cmd.res_set) begin
         status_in = cmd.res_status;
         unique case (cmd.res_idx)
            IDX_HI:  index_in = hi_ff[IDX_W-1:0];
            IDX_MID: index_in = mid_ff[IDX_W-1:0];
            default: index_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      index_ff  <= index_in;
   end

   assign rsp_data.status      = status_ff;
   assign rsp_data.match_index = index_ff;

   a_bin_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.bin_issue |-> (mid_calc >= lo_ff && mid_calc <= hi_ff))
      else $error("binary probe outside its bracket");

   a_exp_below_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.exp_issue |-> (hi_ff < limit_ff && hi_ff < count_sat))
      else $error("doubling probe beyond limit or present count");

endmodule

@@ rtl/ese_ctrl.sv @@
// ----------------------------------------------------------------------------
// ese_ctrl: search sequencer
// Checks one item, walks a search through the entry 0 check, the doubling
// probes, the bracket clamp and the binary probes, and strobes the result.
// ----------------------------------------------------------------------------
module ese_ctrl import ese_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output logic     busy,
   output logic     start_accept,
   output logic     rsp_valid,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   assign busy         = (state_ff != S_IDLE);
   assign start_accept = start && !busy;
   assign rsp_valid    = (state_ff == S_RESP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_START;
         end
         S_START: begin
            priority if (stat.is_write || stat.limit_zero || stat.absent0) begin
               state_in = S_RESP;
            end else begin
               state_in = S_EXP_TEST;
            end
         end
         S_EXP_TEST: begin
            state_in = stat.exp_go ? S_EXP_CMP : S_BIN_SETUP;
         end
         S_EXP_CMP: begin
            priority if (stat.cmp_eq) begin
               state_in = S_RESP;
            end else if (stat.probe_zero || stat.cmp_lt) begin
               state_in = S_EXP_TEST;
            end else begin
               state_in = S_BIN_SETUP;
            end
         end
         S_BIN_SETUP: state_in = S_BIN_TEST;
         S_BIN_TEST: begin
            state_in = stat.range_ok ? S_BIN_CMP : S_RESP;
         end
         S_BIN_CMP: begin
            priority if (stat.mid_present && stat.cmp_eq) begin
               state_in = S_RESP;
            end else if (stat.mid_present && stat.cmp_lt) begin
               state_in = S_BIN_TEST;
            end else if (stat.mid_zero) begin
               state_in = S_RESP;
            end else begin
               state_in = S_BIN_TEST;
            end
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.res_status = ST_OK;
      cmd.res_idx    = IDX_ZERO;
      unique case (state_ff)
         S_START: begin
            priority if (stat.is_write) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_OK;
            end else if (stat.limit_zero) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_EMPTY;
            end else if (stat.absent0) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
            end else begin
               cmd.exp_init = 1'b1;
            end
         end
         S_EXP_TEST: begin
            cmd.exp_issue = stat.exp_go;
         end
         S_EXP_CMP: begin
            priority if (stat.cmp_eq) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_OK;
               cmd.res_idx    = IDX_HI;
            end else if (stat.probe_zero || stat.cmp_lt) begin
               cmd.exp_advance = 1'b1;
            end else begin
               cmd.exp_advance = 1'b0;
            end
         end
         S_BIN_SETUP: cmd.bin_setup = 1'b1;
         S_BIN_TEST: begin
            priority if (stat.range_ok) begin
               cmd.bin_issue = 1'b1;
            end else begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
            end
         end
         S_BIN_CMP: begin
            priority if (stat.mid_present && stat.cmp_eq) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_OK;
               cmd.res_idx    = IDX_MID;
            end else if (stat.mid_present && stat.cmp_lt) begin
               cmd.bin_lo_up = 1'b1;
            end else if (stat.mid_zero) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
            end else begin
               cmd.bin_hi_down = 1'b1;
            end
         end
         default: begin
            cmd.res_set = 1'b0;
         end
      endcase
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      start_accept |=> (state_ff == S_START) && !rsp_valid)
      else $error("accepted item did not enter the sequencer");

   a_result_before_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.res_set))
      else $error("result strobed without being set");

endmodule
